// ----- sv/pooled_per_class_stacks_macros.svh -----
// assertion shorthands used by the checker file
`ifndef POOLED_PER_CLASS_STACKS_MACROS_SVH
`define POOLED_PER_CLASS_STACKS_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pooled stacks check failed");

// next-cycle implication, sampled on clock, off during reset
`define PCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pooled stacks check failed");

`endif

// ----- sv/pcs_pkg.sv -----
`default_nettype none

package pcs_pkg;

   localparam int NUM_CLASSES  = 32;
   localparam int POOL_ENTRIES = 1024;
   localparam int DATA_WIDTH   = 16;

   // fixed field widths of the ports
   localparam int CMD_W    = 2;
   localparam int CLASS_W  = 5;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 11;

   localparam int CLS_IDX_W = $clog2(NUM_CLASSES);
   localparam int CLS_CMP_W = CLASS_W + 2;
   localparam int IDX_W     = $clog2(POOL_ENTRIES);
   localparam int CNT_W     = $clog2(POOL_ENTRIES + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH       = 2'd0,
      CMD_POP_NAMED  = 2'd1,
      CMD_POP_LOWEST = 2'd2,
      CMD_CLEAR      = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_POOL_FULL = 2'd1,
      STAT_POP_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             bottom;
      logic [IDX_W-1:0] link;
   } link_word_type;

endpackage

`default_nettype wire

// ----- sv/pcs_control.sv -----
`default_nettype none

module pcs_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output pcs_pkg::ctrl_cmd_type     ctrl
);
   import pcs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.capture = (state_ff == ST_IDLE) && req_valid;
      ctrl.lookup  = (state_ff == ST_READ);
      ctrl.commit  = (state_ff == ST_EXEC) && out_free;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = ctrl.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- sv/pcs_datapath.sv -----
`default_nettype none

module pcs_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pcs_pkg::ctrl_cmd_type          ctrl,
   input  wire logic [pcs_pkg::CMD_W-1:0]      req_command,
   input  wire logic [pcs_pkg::CLASS_W-1:0]    req_class_index,
   input  wire logic [pcs_pkg::VALUE_W-1:0]    req_push_value,
   output logic      [pcs_pkg::VALUE_W-1:0]    rsp_popped_value,
   output logic      [pcs_pkg::CLASS_W-1:0]    rsp_served_class,
   output logic      [pcs_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                rsp_class_now_empty,
   output logic      [pcs_pkg::TOTAL_W-1:0]    rsp_total_entries
);
   import pcs_pkg::*;

   // captured beat
   command_type             cmd_ff;
   logic [CLASS_W-1:0]      cls_ff;
   logic [DATA_WIDTH-1:0]   val_ff;

   // lookup results
   logic [CLS_IDX_W-1:0]    served_ff;
   logic                    found_ff;
   logic [IDX_W-1:0]        entry_ff;
   logic [DATA_WIDTH-1:0]   data_rd_ff;
   link_word_type           link_rd_ff;

   // stack state
   logic [IDX_W-1:0]        class_head_ff [NUM_CLASSES];
   logic [NUM_CLASSES-1:0]  map_ff, map_in;
   logic [IDX_W-1:0]        free_head_ff, free_head_in;
   logic [CNT_W-1:0]        high_water_ff, high_water_in;
   logic [CNT_W-1:0]        total_ff, total_in;

   // entry pool
   logic [DATA_WIDTH-1:0]   data_mem [POOL_ENTRIES];
   link_word_type           link_mem [POOL_ENTRIES];

   // result register
   logic [VALUE_W-1:0]      rsp_popped_ff, rsp_popped_in;
   logic [CLASS_W-1:0]      rsp_served_ff, rsp_served_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [TOTAL_W-1:0]      rsp_total_ff;

   logic [CLS_IDX_W-1:0]    cls_idx, lowest, served_lk;
   logic                    in_range, found_lk, use_free, pool_full;
   logic [IDX_W-1:0]        rd_addr, new_entry;

   logic                    head_we;
   logic [CLS_IDX_W-1:0]    head_idx;
   logic [IDX_W-1:0]        head_wdata;
   logic                    data_we;
   logic                    link_we;
   logic [IDX_W-1:0]        link_waddr;
   link_word_type           link_wdata;

   assign cls_idx   = CLS_IDX_W'(cls_ff);
   assign in_range  = CLS_CMP_W'(cls_ff) < CLS_CMP_W'(NUM_CLASSES);
   assign use_free  = high_water_ff > total_ff;
   assign pool_full = total_ff >= CNT_W'(POOL_ENTRIES);
   assign new_entry = use_free ? free_head_ff : high_water_ff[IDX_W-1:0];

   // lowest non-empty class
   always_comb begin
      lowest = '0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (map_ff[i]) lowest = CLS_IDX_W'(i);
      end
   end

   always_comb begin
      served_lk = (cmd_ff == CMD_POP_LOWEST) ? lowest : cls_idx;
      found_lk  = (cmd_ff == CMD_POP_LOWEST) ? (|map_ff) : (in_range && map_ff[cls_idx]);
      rd_addr   = (cmd_ff == CMD_PUSH) ? free_head_ff : class_head_ff[served_lk];
   end

   // state update and result for the committed beat
   always_comb begin
      map_in        = map_ff;
      free_head_in  = free_head_ff;
      high_water_in = high_water_ff;
      total_in      = total_ff;
      head_we       = 1'b0;
      head_idx      = cls_idx;
      head_wdata    = new_entry;
      data_we       = 1'b0;
      link_we       = 1'b0;
      link_waddr    = new_entry;
      link_wdata    = '{bottom: 1'b1, link: '0};
      rsp_popped_in = '0;
      rsp_served_in = cls_ff;
      rsp_status_in = STAT_OK;
      rsp_empty_in  = 1'b1;
      if (ctrl.commit) begin
         case (cmd_ff)
            CMD_PUSH: begin
               if (!in_range) begin
                  rsp_status_in = STAT_POOL_FULL;
               end else if (pool_full) begin
                  rsp_status_in = STAT_POOL_FULL;
                  rsp_empty_in  = !map_ff[cls_idx];
               end else begin
                  if (use_free) free_head_in = link_rd_ff.link;
                  else high_water_in = high_water_ff + 1'b1;
                  data_we = 1'b1;
                  link_we = 1'b1;
                  if (map_ff[cls_idx]) begin
                     link_wdata = '{bottom: 1'b0, link: class_head_ff[cls_idx]};
                  end
                  head_we          = 1'b1;
                  map_in[cls_idx]  = 1'b1;
                  total_in         = total_ff + 1'b1;
                  rsp_empty_in     = 1'b0;
               end
            end
            CMD_POP_NAMED, CMD_POP_LOWEST: begin
               if (cmd_ff == CMD_POP_LOWEST) rsp_served_in = CLASS_W'(served_ff);
               if (found_ff) begin
                  rsp_popped_in = VALUE_W'(data_rd_ff);
                  if (link_rd_ff.bottom) begin
                     map_in[served_ff] = 1'b0;
                  end else begin
                     head_we    = 1'b1;
                     head_idx   = served_ff;
                     head_wdata = link_rd_ff.link;
                  end
                  // released entry goes to the front of the free list
                  link_we      = 1'b1;
                  link_waddr   = entry_ff;
                  link_wdata   = '{bottom: 1'b0, link: free_head_ff};
                  free_head_in = entry_ff;
                  total_in     = total_ff - 1'b1;
                  rsp_empty_in = link_rd_ff.bottom;
               end else begin
                  rsp_status_in = STAT_POP_EMPTY;
               end
            end
            default: begin
               map_in        = '0;
               free_head_in  = '0;
               high_water_in = '0;
               total_in      = '0;
               rsp_served_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff        <= '0;
         free_head_ff  <= '0;
         high_water_ff <= '0;
         total_ff      <= '0;
      end else begin
         map_ff        <= map_in;
         free_head_ff  <= free_head_in;
         high_water_ff <= high_water_in;
         total_ff      <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= command_type'(req_command);
         cls_ff <= req_class_index;
         val_ff <= DATA_WIDTH'(req_push_value);
      end
      if (ctrl.lookup) begin
         served_ff  <= served_lk;
         found_ff   <= found_lk;
         entry_ff   <= rd_addr;
         data_rd_ff <= data_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
      if (head_we) class_head_ff[head_idx] <= head_wdata;
      if (data_we) data_mem[new_entry] <= val_ff;
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (ctrl.commit) begin
         rsp_popped_ff <= rsp_popped_in;
         rsp_served_ff <= rsp_served_in;
         rsp_status_ff <= rsp_status_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_total_ff  <= TOTAL_W'(total_in);
      end
   end

   assign rsp_popped_value    = rsp_popped_ff;
   assign rsp_served_class    = rsp_served_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_class_now_empty = rsp_empty_ff;
   assign rsp_total_entries   = rsp_total_ff;

endmodule

`default_nettype wire

// ----- sv/pooled_per_class_stacks.sv -----
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------------------
// req      | in        | req_valid/req_stall  | command, class_index, push_value
// rsp      | out       | rsp_valid/rsp_stall  | popped_value, served_class, status,
//          |           |                      | class_now_empty, total_entries
//
// sequence: a beat passes capture at accept, lookup and commit in turn; the result
//   register loads at commit, and the next beat can be taken in the cycle after commit,
//   so one beat is in flight at a time and no new beat is accepted until the last commits
// the step order is set by the class head select feeding the registered pool read, whose link
//   and data then drive the state update in the commit cycle
// reset: synchronous, active high; clears the control state, the class map and the pool
//   counters; no clearing pass, entries are tracked by the class map and high-water mark
// stalls: a held result does not block a new accept; commit waits while it is held
`default_nettype none

module pooled_per_class_stacks (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [pcs_pkg::CMD_W-1:0]      req_command,
   input  wire logic [pcs_pkg::CLASS_W-1:0]    req_class_index,
   input  wire logic [pcs_pkg::VALUE_W-1:0]    req_push_value,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [pcs_pkg::VALUE_W-1:0]    rsp_popped_value,
   output logic      [pcs_pkg::CLASS_W-1:0]    rsp_served_class,
   output logic      [pcs_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                rsp_class_now_empty,
   output logic      [pcs_pkg::TOTAL_W-1:0]    rsp_total_entries
);
   import pcs_pkg::*;

   // step strobes from the sequencer to the datapath
   ctrl_cmd_type ctrl;

   // sequencer: idle, lookup (registered pool read), commit (state update + result load)
   pcs_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   // class heads, free list, counters, entry pool and result register
   pcs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .req_command         (req_command),
      .req_class_index     (req_class_index),
      .req_push_value      (req_push_value),
      .rsp_popped_value    (rsp_popped_value),
      .rsp_served_class    (rsp_served_class),
      .rsp_status          (rsp_status),
      .rsp_class_now_empty (rsp_class_now_empty),
      .rsp_total_entries   (rsp_total_entries)
   );

endmodule

`default_nettype wire

// ----- sv/pcs_checker.sv -----
`default_nettype none
`include "pooled_per_class_stacks_macros.svh"

module pcs_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [pcs_pkg::VALUE_W-1:0]    rsp_popped_value,
   input wire logic [pcs_pkg::CLASS_W-1:0]    rsp_served_class,
   input wire logic [pcs_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic                           rsp_class_now_empty,
   input wire logic [pcs_pkg::TOTAL_W-1:0]    rsp_total_entries
);
   import pcs_pkg::*;

   logic [VALUE_W+CLASS_W+STATUS_W+TOTAL_W:0] rsp_payload;
   logic                                      status_known;
   logic                                      pop_missed;

   assign rsp_payload  = {rsp_popped_value, rsp_served_class, rsp_status,
                          rsp_class_now_empty, rsp_total_entries};
   assign status_known = rsp_status inside {STAT_OK, STAT_POOL_FULL, STAT_POP_EMPTY};
   assign pop_missed   = rsp_valid && (rsp_status == STAT_POP_EMPTY);

   // a held result beat keeps its payload
   `PCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // only the three defined status codes come out
   `PCS_ASSERT_SAME(a_status_code, rsp_valid, status_known)

   // a failed pop returns no data and an empty class
   `PCS_ASSERT_SAME(a_empty_pop, pop_missed, rsp_popped_value == '0 && rsp_class_now_empty)

   // one beat in flight: an accept closes the request side for the next cycle
   `PCS_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

endmodule

bind pooled_per_class_stacks pcs_checker u_pcs_checker (.*);

`default_nettype wire
